[src/ltt_pkg.sv]
// ----------------------------------------------------------------------------
// ltt_pkg: shared types and codes for the lock tracking table
// Beat structs for both channels, command and status codes, queue entry.
// ----------------------------------------------------------------------------
`default_nettype none
package ltt_pkg;

  localparam logic [2:0] CMD_REGISTER = 3'd0;
  localparam logic [2:0] CMD_ACQUIRE  = 3'd1;
  localparam logic [2:0] CMD_RELEASE  = 3'd2;
  localparam logic [2:0] CMD_NACQUIRE = 3'd3;
  localparam logic [2:0] CMD_NRELEASE = 3'd4;
  localparam logic [2:0] CMD_LOOKUP   = 3'd5;
  localparam logic [2:0] CMD_DESTROY  = 3'd6;
  localparam logic [2:0] CMD_UNUSED   = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] lock_key;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] lock_handle;
    logic [31:0] acquire_count;
    logic [15:0] nest_depth;
  } out_beat_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic        is_reg;
    logic        is_unused;
    logic [2:0]  cmd;
    logic [63:0] lock_key;
  } job_t;

endpackage
`default_nettype wire

[src/ltt_front.sv]
// ----------------------------------------------------------------------------
// ltt_front: input stage and job queue
// Accepts command beats, classifies them and holds them in a small FIFO.
// ----------------------------------------------------------------------------
`default_nettype none
module ltt_front (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_push,
  output logic            in_full,
  input  ltt_pkg::in_beat_t in_data,
  output logic            job_valid,
  input  wire             job_take,
  output ltt_pkg::job_t   job
);
  import ltt_pkg::*;

  job_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  job_t       j;

  assign in_full   = cnt_r[1];
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];

  // classify incoming beat
  always_comb begin
    j.cmd       = in_data.cmd;
    j.lock_key  = in_data.lock_key;
    j.is_reg    = (in_data.cmd == CMD_REGISTER);
    j.is_unused = (in_data.cmd == CMD_UNUSED);
  end

  wire do_push = in_push && !in_full;
  wire do_pop  = job_take && job_valid;

  // hold payload
  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= j;
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule
`default_nettype wire

[src/ltt_back.sv]
// ----------------------------------------------------------------------------
// ltt_back: table engine
// Scans live entries in turn, updates the match and writes the result.
// ----------------------------------------------------------------------------
`default_nettype none
module ltt_back #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              job_valid,
  output logic             job_take,
  input  ltt_pkg::job_t    job,
  output logic             out_empty,
  input  wire              out_pop,
  output ltt_pkg::out_beat_t out_data
);
  import ltt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_MVRD = 3'd4;
  localparam logic [2:0] S_MVWR = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [63:0] key_mem [TABLE_DEPTH];
  logic [79:0] val_mem [TABLE_DEPTH]; // handle, order, nest

  logic [2:0]    st_r, st_nxt;
  logic [CW-1:0] live_r;
  logic [31:0]   hnd_r;
  logic [AW-1:0] idx_r, slot_r;
  logic [63:0]   krd_r;
  logic [79:0]   vrd_r;
  job_t          cur_r;
  out_beat_t     res_r;
  logic          full_r;

  assign out_empty = !full_r;
  assign out_data  = res_r;
  assign job_take  = (st_r == S_IDLE) && job_valid && !full_r;

  wire [CW-1:0] idx_w = CW'(idx_r);
  wire [AW-1:0] last  = AW'(live_r - 1'b1);

  // read ports, registered
  always_ff @(posedge clk) begin
    krd_r <= key_mem[(st_r == S_MVRD) ? last : idx_r];
    vrd_r <= val_mem[(st_r == S_MVRD) ? last : idx_r];
  end

  // next entry values after the update
  logic [31:0] ord_n;
  logic [15:0] nst_n;
  always_comb begin
    ord_n = vrd_r[47:16];
    nst_n = vrd_r[15:0];
    unique case (cur_r.cmd)
      CMD_ACQUIRE: ord_n = vrd_r[47:16] + 32'd1;
      CMD_NACQUIRE: begin
        if (vrd_r[15:0] == 16'd0) ord_n = vrd_r[47:16] + 32'd1;
        if (vrd_r[15:0] != 16'hFFFF) nst_n = vrd_r[15:0] + 16'd1;
      end
      CMD_NRELEASE: if (vrd_r[15:0] != 16'd0) nst_n = vrd_r[15:0] - 16'd1;
      default: ;
    endcase
  end

  // write port
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && job_take && job.is_reg && live_r < DEPTH_C) begin
      key_mem[live_r[AW-1:0]] <= job.lock_key;
      val_mem[live_r[AW-1:0]] <= {hnd_r, 32'd0, 16'd0};
    end else if (st_r == S_UPD) begin
      val_mem[slot_r] <= {vrd_r[79:48], ord_n, nst_n};
    end else if (st_r == S_MVWR) begin
      key_mem[slot_r] <= krd_r;
      val_mem[slot_r] <= vrd_r;
    end
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (job_take) begin
        if (job.is_reg || job.is_unused) st_nxt = S_IDLE;
        else if (live_r == '0) st_nxt = S_OUT;
        else st_nxt = S_RD;
      end
      S_RD:  st_nxt = S_CMP;
      S_CMP: begin
        if (krd_r == cur_r.lock_key) st_nxt = S_UPD;
        else if (idx_w + 1'b1 >= live_r) st_nxt = S_OUT;
        else st_nxt = S_RD;
      end
      S_UPD:  st_nxt = (cur_r.cmd == CMD_DESTROY) ? S_MVRD : S_IDLE;
      S_MVRD: st_nxt = S_MVWR;
      S_MVWR: st_nxt = S_IDLE;
      S_OUT:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; live_r <= '0; hnd_r <= '0; full_r <= 1'b0; idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (out_pop && full_r) full_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (job_take) begin
          cur_r <= job;
          idx_r <= '0;
          if (job.is_unused) begin
            res_r <= '0; full_r <= 1'b1;
          end else if (job.is_reg) begin
            full_r <= 1'b1;
            if (live_r < DEPTH_C) begin
              res_r  <= '{ST_OK, hnd_r, 32'd0, 16'd0};
              hnd_r  <= hnd_r + 32'd1;
              live_r <= live_r + 1'b1;
            end else begin
              res_r <= '{ST_FULL, 32'd0, 32'd0, 16'd0};
            end
          end
        end
        S_CMP: begin
          slot_r <= idx_r;
          if (krd_r != cur_r.lock_key) idx_r <= idx_r + 1'b1;
        end
        S_UPD: begin
          res_r  <= '{ST_OK, vrd_r[79:48], ord_n, nst_n};
          full_r <= 1'b1;
        end
        S_MVWR: live_r <= live_r - 1'b1;
        S_OUT: begin
          res_r  <= '{ST_NOTFOUND, 32'd0, 32'd0, 16'd0};
          full_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[src/lock_tracking_table_core.sv]
// ----------------------------------------------------------------------------
// lock_tracking_table_core: table of tracked locks keyed by lock address
// Front queue takes commands; back engine searches and updates the table.
// ----------------------------------------------------------------------------
//  channel | handshake      | beat
//  in      | in_push/full   | cmd, lock_key
//  out     | out_pop/empty  | status, lock_handle, acquire_count, nest_depth
//
//  Register and unused commands do not scan. Other commands scan the live
//  entries in turn, each with a memory read and then a compare; destroy then
//  moves the last entry into the freed slot. Reset (rst_n, synchronous) clears
//  counters; table contents are undefined until written. A result waiting on
//  out_pop stalls the engine; the two-entry input queue keeps accepting until
//  full.
`default_nettype none
module lock_tracking_table_core #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_push,
  output logic               full,
  input  ltt_pkg::in_beat_t  in_data,
  output logic               empty,
  input  wire                pop,
  output ltt_pkg::out_beat_t out_data
);
  import ltt_pkg::*;

  logic job_valid, job_take;
  job_t job;

  ltt_front u_front (
    .clk, .rst_n, .in_push, .in_full(full), .in_data,
    .job_valid, .job_take, .job
  );

  ltt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst_n, .job_valid, .job_take, .job,
    .out_empty(empty), .out_pop(pop), .out_data
  );
endmodule
`default_nettype wire

[src/ltt_checker.sv]
// ----------------------------------------------------------------------------
// ltt_checker: port-level checks for the lock tracking table
// Watches result beats for consistent status and field values.
// ----------------------------------------------------------------------------
`default_nettype none
module ltt_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                empty,
  input wire                pop,
  input ltt_pkg::out_beat_t out_data
);
  import ltt_pkg::*;

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_data)) else $error("result dropped");

  // status is one of the defined codes
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_data.status != 2'd3) else $error("bad status");

  // not found and full carry zero fields
  a_nf: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_data.status == ST_NOTFOUND || out_data.status == ST_FULL) |->
    out_data.lock_handle == 32'd0 && out_data.acquire_count == 32'd0 &&
    out_data.nest_depth == 16'd0) else $error("nonzero fields on error");
endmodule

bind lock_tracking_table_core ltt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .out_data(out_data)
);
`default_nettype wire
